// ----- rtl/iso15693_response_decoder_assert.svh -----
// Assertion macros for the ISO 15693 response decoder
`ifndef ISO15693_RESPONSE_DECODER_ASSERT_SVH
`define ISO15693_RESPONSE_DECODER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ISODEC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ISODEC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/isodec_pkg.sv -----
// Shared types, constants and CRC helper for the ISO 15693 response decoder
`timescale 1ns / 1ps
`default_nettype none

package isodec_pkg;

  localparam int MaxBytesDef = 512;
  localparam int QDepth      = 4;

  localparam logic [15:0] CrcPoly   = 16'h8408;
  localparam logic [15:0] CrcPreset = 16'hFFFF;
  localparam logic [4:0]  SofValue  = 5'h17;
  localparam logic [11:0] TallyMax  = 12'hFFF;

  localparam logic [1:0] PairOne  = 2'b10;
  localparam logic [1:0] PairZero = 2'b01;

  localparam logic [1:0] StOk  = 2'd0;
  localparam logic [1:0] StTag = 2'd1;
  localparam logic [1:0] StCrc = 2'd2;

  typedef struct packed {
    logic        has_byte;
    logic [7:0]  data;
    logic        is_last;
    logic        sof_ok;
    logic [11:0] coll;
  } qent_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/iso15693_response_decoder.sv -----
// Top level of the ISO 15693 tag response decoder
//
//  channel | direction | handshake           | beat payload
//  in      | input     | in_valid / in_stall   | code_byte, last_code_byte
//  out     | output    | out_valid / out_stall | is_status, data_byte, byte_index, status,
//          |           |                       | collision_count, byte_total, last_of_run
//
// One code byte per cycle while the 4-entry queue has room; the front end decodes
// all pairs of a byte combinationally. The back end gives one result beat per cycle
// unless stalled; a last byte ending a data byte gives a data beat, then a status beat.
// rst is synchronous and returns all frame state to waiting for start of frame.
// out_stall holds the output register; in_stall rises only when the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module iso15693_response_decoder
  import isodec_pkg::*;
#(
  parameter int MAX_BYTES = MaxBytesDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  code_byte,
  input  wire logic        last_code_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             is_status,
  output logic [7:0]       data_byte,
  output logic [8:0]       byte_index,
  output logic [1:0]       status,
  output logic [11:0]      collision_count,
  output logic [9:0]       byte_total,
  output logic             last_of_run
);

`include "iso15693_response_decoder_assert.svh"

  qent_t push_data;
  qent_t head;
  logic  push;
  logic  pop;
  logic  empty;
  logic  full;

  assign in_stall = full;

  isodec_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (in_valid && !in_stall),
    .code_byte      (code_byte),
    .last_code_byte (last_code_byte),
    .push_data      (push_data),
    .push           (push)
  );

  isodec_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  isodec_back #(
    .MAX_BYTES (MAX_BYTES)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .empty           (empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .is_status       (is_status),
    .data_byte       (data_byte),
    .byte_index      (byte_index),
    .status          (status),
    .collision_count (collision_count),
    .byte_total      (byte_total),
    .last_of_run     (last_of_run)
  );

  `ISODEC_ASSERT_NOW(a_ok_min_len, out_valid && is_status && (status == StOk), byte_total >= 10'd3, "ok status with short frame")
  `ISODEC_ASSERT_NOW(a_tag_zero_total, out_valid && is_status && (status == StTag), byte_total == 10'd0, "tag error with nonzero total")
  `ISODEC_ASSERT_NOW(a_data_fields, out_valid && !is_status, (status == StOk) && (byte_total == 10'd0) && (collision_count == 12'd0), "data beat carries status fields")
  `ISODEC_ASSERT_NEXT(a_full_blocks, full && !pop, full, "queue drained without pop")

endmodule

`default_nettype wire

// ----- rtl/isodec_front.sv -----
// Front end: SOF check, bit-pair decode, byte assembly and collision tally
`timescale 1ns / 1ps
`default_nettype none

module isodec_front
  import isodec_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] code_byte,
  input  wire logic       last_code_byte,
  output qent_t           push_data,
  output logic            push
);

  logic        awaiting_start;
  logic        start_seen;
  logic [2:0]  holder;
  logic [1:0]  held_cnt;
  logic [7:0]  asm_byte;
  logic [2:0]  bits_in_byte;
  logic [11:0] tally;

  logic [10:0] bits_all;
  logic        five_pairs;
  logic        processing;
  logic        sof_match;
  logic [7:0]  byte_v;
  logic [2:0]  cnt_v;
  logic [2:0]  ncoll;
  logic        done;
  logic [7:0]  done_byte;
  logic [1:0]  pair;
  logic [12:0] tsum;
  logic [11:0] tally_upd;
  logic        sof_ok;

  assign processing = !awaiting_start && start_seen;
  assign sof_match  = (code_byte[4:0] == SofValue);
  assign bits_all   = ({3'b000, code_byte} << held_cnt) | {8'h00, holder};
  assign five_pairs = (held_cnt == 2'd3);

  always_comb begin
    byte_v    = asm_byte;
    cnt_v     = bits_in_byte;
    ncoll     = '0;
    done      = 1'b0;
    done_byte = '0;
    pair      = '0;
    for (int i = 0; i < 5; i++) begin
      if ((i < 4) || five_pairs) begin
        pair = bits_all[2*i +: 2];
        if (pair == PairOne) begin
          byte_v[cnt_v] = 1'b1;
        end else if (pair != PairZero) begin
          ncoll = ncoll + 3'd1;
        end
        if (cnt_v == 3'd7) begin
          done      = 1'b1;
          done_byte = byte_v;
          byte_v    = '0;
        end
        cnt_v = cnt_v + 3'd1;
      end
    end
  end

  assign tsum      = {1'b0, tally} + {10'd0, ncoll};
  assign tally_upd = !processing ? tally : (tsum[12] ? TallyMax : tsum[11:0]);
  assign sof_ok    = awaiting_start ? sof_match : start_seen;

  assign push = accept && ((processing && done) || last_code_byte);

  always_comb begin
    push_data          = '0;
    push_data.has_byte = processing && done;
    push_data.data     = done_byte;
    push_data.is_last  = last_code_byte;
    push_data.sof_ok   = sof_ok;
    push_data.coll     = sof_ok ? tally_upd : 12'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_start <= 1'b1;
      start_seen     <= 1'b0;
      holder         <= '0;
      held_cnt       <= '0;
      asm_byte       <= '0;
      bits_in_byte   <= '0;
      tally          <= '0;
    end else if (accept) begin
      if (last_code_byte) begin
        awaiting_start <= 1'b1;
        start_seen     <= 1'b0;
        holder         <= '0;
        held_cnt       <= '0;
        asm_byte       <= '0;
        bits_in_byte   <= '0;
        tally          <= '0;
      end else if (awaiting_start) begin
        awaiting_start <= 1'b0;
        if (sof_match) begin
          start_seen <= 1'b1;
          holder     <= code_byte[7:5];
          held_cnt   <= 2'd3;
        end
      end else if (start_seen) begin
        holder       <= {2'b00, (five_pairs ? bits_all[10] : bits_all[8])};
        held_cnt     <= 2'd1;
        asm_byte     <= byte_v;
        bits_in_byte <= cnt_v;
        tally        <= tally_upd;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/isodec_queue.sv -----
// Short queue between front end and back end
`timescale 1ns / 1ps
`default_nettype none

module isodec_queue
  import isodec_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire qent_t push_data,
  input  wire logic  pop,
  output qent_t      head,
  output logic       empty,
  output logic       full
);

  localparam int PtrW = $clog2(QDepth);

  qent_t           entries [QDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (PtrW+1)'(QDepth));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + (PtrW+1)'(1);
        2'b01:   count <= count - (PtrW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/isodec_back.sv -----
// Back end: byte count, CRC-16 check, result formatting and output register
`timescale 1ns / 1ps
`default_nettype none

module isodec_back
  import isodec_pkg::*;
#(
  parameter int MAX_BYTES = MaxBytesDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire qent_t       head,
  input  wire logic        empty,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             is_status,
  output logic [7:0]       data_byte,
  output logic [8:0]       byte_index,
  output logic [1:0]       status,
  output logic [11:0]      collision_count,
  output logic [9:0]       byte_total,
  output logic             last_of_run
);

  localparam int CntRaw = $clog2(MAX_BYTES + 1);
  localparam int CntW   = (CntRaw > 10) ? CntRaw : 10;

  logic [CntW-1:0] count;
  logic [15:0]     crc;
  logic [15:0]     last_two;
  logic            overflow;
  logic            byte_done;

  logic            go;
  logic            byte_phase;
  logic            room;
  logic            tag_err;
  logic [15:0]     got;
  logic [1:0]      st_v;

  assign go         = !empty && (!out_valid || !out_stall);
  assign byte_phase = head.has_byte && !byte_done;
  assign room       = (count < CntW'(MAX_BYTES));
  assign pop        = go && (!byte_phase || !head.is_last);

  assign tag_err = !head.sof_ok || overflow || (count < CntW'(3));
  assign got     = {last_two[7:0], last_two[15:8]};
  assign st_v    = tag_err ? StTag : ((~crc == got) ? StOk : StCrc);

  always_ff @(posedge clk) begin
    if (go) begin
      if (byte_phase) begin
        is_status       <= 1'b0;
        data_byte       <= head.data;
        byte_index      <= count[8:0];
        status          <= StOk;
        collision_count <= '0;
        byte_total      <= '0;
        last_of_run     <= !head.is_last;
      end else begin
        is_status       <= 1'b1;
        data_byte       <= '0;
        byte_index      <= '0;
        status          <= st_v;
        collision_count <= head.coll;
        byte_total      <= tag_err ? 10'd0 : count[9:0];
        last_of_run     <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      count     <= '0;
      crc       <= CrcPreset;
      last_two  <= '0;
      overflow  <= 1'b0;
      byte_done <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (go) begin
        if (byte_phase) begin
          if (room) begin
            out_valid <= 1'b1;
            if (count >= CntW'(2)) begin
              crc <= crc_byte(crc, last_two[15:8]);
            end
            last_two <= {last_two[7:0], head.data};
            count    <= count + CntW'(1);
          end else begin
            overflow <= 1'b1;
          end
          byte_done <= head.is_last;
        end else begin
          out_valid <= 1'b1;
          count     <= '0;
          crc       <= CrcPreset;
          last_two  <= '0;
          overflow  <= 1'b0;
          byte_done <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- verif/response_decode_checker.sv -----
// Checker that predicts decoded bytes and frame status of the ISO 15693 response decoder
`timescale 1ns / 1ps

module response_decode_checker
  import isodec_pkg::*;
#(
  parameter int MaxBytes = MaxBytesDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  code_byte,
  input  logic        last_code_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        is_status,
  input  logic [7:0]  data_byte,
  input  logic [8:0]  byte_index,
  input  logic [1:0]  status,
  input  logic [11:0] collision_count,
  input  logic [9:0]  byte_total,
  input  logic        last_of_run,
  output int          failures,
  output int          pending,
  output int          beats_seen
);

  typedef struct packed {
    logic        is_status;
    logic [7:0]  data;
    logic [8:0]  index;
    logic [1:0]  status;
    logic [11:0] coll;
    logic [9:0]  total;
    logic        last;
  } result_beat_t;

  result_beat_t expected_beats[$];

  logic        sof_wait;
  logic        sof_found;
  logic        overflow;
  logic [10:0] pair_bits;
  logic [3:0]  pair_bit_cnt;
  logic [7:0]  byte_acc;
  logic [2:0]  bit_pos;
  logic [11:0] coll_tally;
  logic [12:0] byte_cnt;
  logic [15:0] crc_acc;
  logic [15:0] tail_pair;

  task automatic clear_frame_state();
    sof_wait     = 1'b1;
    sof_found    = 1'b0;
    overflow     = 1'b0;
    pair_bits    = '0;
    pair_bit_cnt = '0;
    byte_acc     = '0;
    bit_pos      = '0;
    coll_tally   = '0;
    byte_cnt     = '0;
    crc_acc      = CrcPreset;
    tail_pair    = '0;
  endtask

  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c = c >> 1;
      if (fb) c = c ^ CrcPoly;
    end
    return c;
  endfunction

  task automatic decode_code_byte(input logic [7:0] cb, input logic lst);
    result_beat_t step_beats[$];
    result_beat_t beat;
    logic [1:0]   pair;
    logic [15:0]  got;
    if (sof_wait) begin
      sof_wait = 1'b0;
      if (cb[4:0] == SofValue) begin
        sof_found    = 1'b1;
        pair_bits    = {8'h00, cb[7:5]};
        pair_bit_cnt = 4'd3;
      end
    end else if (sof_found) begin
      pair_bits    = pair_bits | (11'(cb) << pair_bit_cnt[1:0]);
      pair_bit_cnt = pair_bit_cnt + 4'd8;
      while (pair_bit_cnt >= 4'd2) begin
        pair = pair_bits[1:0];
        if (pair == PairOne) begin
          byte_acc[bit_pos] = 1'b1;
        end else if (pair != PairZero && coll_tally != TallyMax) begin
          coll_tally = coll_tally + 12'd1;
        end
        pair_bits    = pair_bits >> 2;
        pair_bit_cnt = pair_bit_cnt - 4'd2;
        if (bit_pos == 3'd7) begin
          if (byte_cnt < MaxBytes) begin
            beat       = '0;
            beat.data  = byte_acc;
            beat.index = byte_cnt[8:0];
            step_beats.push_back(beat);
            if (byte_cnt >= 2) crc_acc = crc16_update(crc_acc, tail_pair[15:8]);
            tail_pair = {tail_pair[7:0], byte_acc};
            byte_cnt  = byte_cnt + 13'd1;
          end else begin
            overflow = 1'b1;
          end
          byte_acc = '0;
          bit_pos  = '0;
        end else begin
          bit_pos = bit_pos + 3'd1;
        end
      end
    end

    if (lst) begin
      beat           = '0;
      beat.is_status = 1'b1;
      beat.status    = StTag;
      if (sof_found) beat.coll = coll_tally;
      if (sof_found && !overflow && byte_cnt >= 3) begin
        // FCS travels low byte first
        got         = {tail_pair[7:0], tail_pair[15:8]};
        beat.status = (~crc_acc == got) ? StOk : StCrc;
        beat.total  = byte_cnt[9:0];
      end
      step_beats.push_back(beat);
      clear_frame_state();
    end

    if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
    foreach (step_beats[k]) expected_beats.push_back(step_beats[k]);
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      failures++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_result(input result_beat_t act);
    result_beat_t exp_beat;
    if (expected_beats.size() == 0) begin
      failures++;
      $display("%0t: result beat with nothing expected: status_beat=%0b data=%0h status=%0h",
               $time, act.is_status, act.data, act.status);
    end else begin
      exp_beat = expected_beats.pop_front();
      check_field("is_status", 16'(exp_beat.is_status), 16'(act.is_status));
      check_field("data_byte", 16'(exp_beat.data), 16'(act.data));
      check_field("byte_index", 16'(exp_beat.index), 16'(act.index));
      check_field("status", 16'(exp_beat.status), 16'(act.status));
      check_field("collision_count", 16'(exp_beat.coll), 16'(act.coll));
      check_field("byte_total", 16'(exp_beat.total), 16'(act.total));
      check_field("last_of_run", 16'(exp_beat.last), 16'(act.last));
    end
  endtask

  initial begin
    failures   = 0;
    beats_seen = 0;
    clear_frame_state();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_frame_state();
      expected_beats.delete();
      pending <= 0;
    end else begin
      if (in_valid && !in_stall) decode_code_byte(code_byte, last_code_byte);
      if (out_valid && !out_stall) begin
        beats_seen++;
        check_result({is_status, data_byte, byte_index, status, collision_count, byte_total,
                      last_of_run});
      end
      pending <= expected_beats.size();
    end
  end

endmodule

// ----- verif/testbench.sv -----
// Testbench top: response stimulus, handshake pacing and verdict for the response decoder
`timescale 1ns / 1ps

module testbench;
  import isodec_pkg::*;

  localparam int SmallItems    = 560;
  localparam int PhaseItems    = 140;
  localparam int LongCodeBytes = 1040;
  localparam int HoldCycles    = 300;
  localparam int IdleLimit     = 3000;
  localparam int DrainCycles   = 16;

  typedef enum int {PaceFree, PaceSenderIdle, PaceReceiverStall, PaceBoth} pace_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  code_byte;
  logic        last_code_byte;
  logic        out_valid;
  logic        out_stall;
  logic        is_status;
  logic [7:0]  data_byte;
  logic [8:0]  byte_index;
  logic [1:0]  status;
  logic [11:0] collision_count;
  logic [9:0]  byte_total;
  logic        last_of_run;

  int failures;
  int pending;
  int beats_seen;
  int in_idle_pct;
  int out_stall_pct;
  int hold_req;
  int hold_left;
  int quiet_cycles;
  int codes_sent;
  int ignored_codes;
  int responses_sent;

  iso15693_response_decoder #(.MAX_BYTES(MaxBytesDef)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .code_byte(code_byte), .last_code_byte(last_code_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .is_status(is_status), .data_byte(data_byte), .byte_index(byte_index),
    .status(status), .collision_count(collision_count), .byte_total(byte_total),
    .last_of_run(last_of_run)
  );

  response_decode_checker #(.MaxBytes(MaxBytesDef)) decode_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .code_byte(code_byte), .last_code_byte(last_code_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .is_status(is_status), .data_byte(data_byte), .byte_index(byte_index),
    .status(status), .collision_count(collision_count), .byte_total(byte_total),
    .last_of_run(last_of_run),
    .failures(failures), .pending(pending), .beats_seen(beats_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver pacing; a requested hold-off is counted here
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req != 0) begin
        hold_req  = 0;
        hold_left = HoldCycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < out_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("watchdog: no beat moved for %0d cycles", IdleLimit);
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_pace(input pace_t p);
    case (p)
      PaceFree:          begin in_idle_pct = 0;  out_stall_pct = 0;  end
      PaceSenderIdle:    begin in_idle_pct = 45; out_stall_pct = 0;  end
      PaceReceiverStall: begin in_idle_pct = 0;  out_stall_pct = 45; end
      default:           begin in_idle_pct = 8;  out_stall_pct = 8;  end
    endcase
  endtask

  task automatic drive_beat(input logic [7:0] cb, input logic lst);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    code_byte      <= cb;
    last_code_byte <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    codes_sent++;
    if (lst) responses_sent++;
  endtask

  function automatic logic [15:0] crc16_of(input logic [7:0] bytes[$]);
    logic [15:0] c;
    logic fb;
    c = CrcPreset;
    foreach (bytes[i]) begin
      for (int k = 0; k < 8; k++) begin
        fb = c[0] ^ bytes[i][k];
        c = c >> 1;
        if (fb) c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  // Manchester-style pair coding, LSB first, packed behind the 5-bit SOF pattern
  task automatic send_response(input logic [7:0] body[$], input int coll_pct, input int pad_bits);
    logic bits[$];
    logic [7:0] cb;
    logic b;
    foreach (body[i]) begin
      for (int k = 0; k < 8; k++) begin
        if ($urandom_range(99) < coll_pct) begin
          b = 1'($urandom_range(1));
          bits.push_back(b);
          bits.push_back(b);
        end else begin
          bits.push_back(!body[i][k]);
          bits.push_back(body[i][k]);
        end
      end
    end
    repeat (pad_bits) bits.push_back(1'($urandom_range(1)));
    cb = {3'b000, SofValue};
    for (int k = 5; k < 8; k++) cb[k] = (bits.size() > 0) ? bits.pop_front() : 1'($urandom_range(1));
    drive_beat(cb, bits.size() == 0);
    while (bits.size() > 0) begin
      for (int k = 0; k < 8; k++) begin
        cb[k] = (bits.size() > 0) ? bits.pop_front() : 1'($urandom_range(1));
      end
      drive_beat(cb, bits.size() == 0);
    end
  endtask

  task automatic send_checked_frame(input logic [7:0] body[$], input logic corrupt,
                                    input int coll_pct, input int pad_bits);
    logic [15:0] fcs;
    int pos;
    fcs = ~crc16_of(body);
    body.push_back(fcs[7:0]);
    body.push_back(fcs[15:8]);
    if (corrupt) begin
      pos = $urandom_range(body.size() - 1);
      body[pos] = body[pos] ^ (8'h01 << $urandom_range(7));
    end
    send_response(body, coll_pct, pad_bits);
  endtask

  // response whose first byte lacks the SOF pattern; the rest is ignored
  task automatic send_unframed(input int extra);
    logic [7:0] cb;
    do cb = 8'($urandom_range(255)); while (cb[4:0] == SofValue);
    drive_beat(cb, extra == 0);
    for (int k = 0; k < extra; k++) drive_beat(8'($urandom_range(255)), k == extra - 1);
    ignored_codes += extra;
  endtask

  initial begin
    logic [7:0] body[$];
    int roll;
    int start_count;
    rst            = 1'b1;
    in_valid       = 1'b0;
    code_byte      = 8'h00;
    last_code_byte = 1'b0;
    hold_req       = 0;
    codes_sent     = 0;
    ignored_codes  = 0;
    responses_sent = 0;
    set_pace(PaceFree);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: SOF-only, missing SOF, good, short with collisions, bad FCS
    drive_beat({3'b101, SofValue}, 1'b1);
    drive_beat(8'h00, 1'b1);
    drive_beat(8'hFF, 1'b0);
    drive_beat({3'b000, SofValue}, 1'b0);
    drive_beat(8'hAA, 1'b1);
    body = {8'hFF};
    send_checked_frame(body, 1'b0, 0, 5);
    body = {8'h00, 8'h55};
    send_response(body, 50, 0);
    body = {8'h00};
    send_checked_frame(body, 1'b1, 0, 0);

    // random frames; output held off at the start so the input backs up
    start_count = codes_sent - ignored_codes;
    hold_req = 1;
    while (codes_sent - ignored_codes - start_count < SmallItems) begin
      set_pace(pace_t'(((codes_sent - ignored_codes - start_count) / PhaseItems) % 4));
      roll = $urandom_range(99);
      body.delete();
      repeat ($urandom_range(1, 10)) body.push_back(8'($urandom_range(255)));
      if (roll < 60) begin
        send_checked_frame(body, 1'b0, 0, $urandom_range(7));
      end else if (roll < 75) begin
        send_checked_frame(body, roll < 68, (roll >= 68) ? 5 : 0, $urandom_range(7));
      end else if (roll < 83) begin
        body.delete();
        repeat ($urandom_range(2)) body.push_back(8'($urandom_range(255)));
        send_response(body, ($urandom_range(1) != 0) ? 10 : 0, $urandom_range(7));
      end else if (roll < 91) begin
        send_unframed($urandom_range(4));
      end else begin
        send_response(body, 50, $urandom_range(7));
      end
    end

    // overlong frame, nearly all collision pairs: byte cap and tally saturation
    set_pace(PaceBoth);
    drive_beat({3'b000, SofValue}, 1'b0);
    for (int i = 0; i < LongCodeBytes; i++) begin
      drive_beat((i % 173 == 50) ? 8'($urandom_range(255)) : 8'h00, i == LongCodeBytes - 1);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d code bytes in %0d responses (good, bad FCS, short, unframed, noisy, overlong)",
             codes_sent, responses_sent);
    $display("under four pacing mixes and a %0d-cycle output hold; %0d result beats checked.",
             HoldCycles, beats_seen);
    if (failures == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
